// ----- hw/rtl/ese_pkg.sv -----
// Shared constants, control word format and microcode ROM of the encoder speed estimator.
package ese_pkg;

  // Speed history window
  localparam int WINDOW_DEPTH = 4;
  localparam int WIN_AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_PER_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_FLIP      = 1'd1;

  // Serial divider: two quotient bits per step, 32 quotient bits
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Filter taps, scaled by ten; a short window turns into a plain mean
  localparam logic [3:0] W_NEWEST = (WINDOW_DEPTH >= 2) ? 4'd5 : 4'd10;
  localparam logic [3:0] W_PREV   = (WINDOW_DEPTH >= 3) ? 4'd3 :
                                    (WINDOW_DEPTH == 2) ? 4'd5 : 4'd0;
  localparam logic [3:0] W_OLDEST = (WINDOW_DEPTH >= 3) ? 4'd2 : 4'd0;

  // Datapath operations
  typedef logic [3:0] ese_op_t;
  localparam ese_op_t OP_NOP       = 4'd0;
  localparam ese_op_t OP_LOAD      = 4'd1;
  localparam ese_op_t OP_MUL       = 4'd2;
  localparam ese_op_t OP_SPD_INIT  = 4'd3;
  localparam ese_op_t OP_DIV_STEP  = 4'd4;
  localparam ese_op_t OP_SPD_STORE = 4'd5;
  localparam ese_op_t OP_FCLR      = 4'd6;
  localparam ese_op_t OP_FACC      = 4'd7;
  localparam ese_op_t OP_FLT_INIT  = 4'd8;
  localparam ese_op_t OP_OUT       = 4'd9;
  localparam ese_op_t OP_RMAC      = 4'd10;

  // Branch conditions: taken -> target, otherwise fall through
  typedef logic [1:0] ese_cond_t;
  localparam ese_cond_t C_NEVER    = 2'd0;
  localparam ese_cond_t C_NO_INPUT = 2'd1;
  localparam ese_cond_t C_DIV_MORE = 2'd2;
  localparam ese_cond_t C_OUT_BUSY = 2'd3;

  localparam int PC_W   = 4;
  localparam int NSTEPS = 15;
  localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV_SPD = 4'd4;
  localparam logic [PC_W-1:0] PC_OUT     = 4'd14;

  typedef struct packed {
    ese_op_t         op;
    logic [1:0]      rd_back;   // window read: slots behind the write pointer
    logic [3:0]      weight;
    ese_cond_t       cond;
    logic [PC_W-1:0] target;
  } ese_uop_t;

  typedef struct packed {
    logic in_valid;
    logic div_last;
    logic out_busy;
  } ese_stat_t;

  function automatic ese_uop_t ucode(input logic [PC_W-1:0] pc);
    ese_uop_t u;
    unique case (pc)
      4'd0:  u = '{op: OP_LOAD,      rd_back: 2'd0, weight: 4'd0,     cond: C_NO_INPUT,
                   target: PC_IDLE};
      4'd1:  u = '{op: OP_MUL,       rd_back: 2'd0, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
      4'd2:  u = '{op: OP_MUL,       rd_back: 2'd0, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
      4'd3:  u = '{op: OP_SPD_INIT,  rd_back: 2'd0, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
      4'd4:  u = '{op: OP_DIV_STEP,  rd_back: 2'd0, weight: 4'd0,     cond: C_DIV_MORE,
                   target: PC_DIV_SPD};
      4'd5:  u = '{op: OP_SPD_STORE, rd_back: 2'd0, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
      4'd6:  u = '{op: OP_FCLR,      rd_back: 2'd1, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
      4'd7:  u = '{op: OP_FACC,      rd_back: 2'd2, weight: W_NEWEST, cond: C_NEVER,
                   target: PC_IDLE};
      4'd8:  u = '{op: OP_FACC,      rd_back: 2'd3, weight: W_PREV,   cond: C_NEVER,
                   target: PC_IDLE};
      4'd9:  u = '{op: OP_FACC,      rd_back: 2'd0, weight: W_OLDEST, cond: C_NEVER,
                   target: PC_IDLE};
      4'd10: u = '{op: OP_FLT_INIT,  rd_back: 2'd0, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
      4'd11: u = '{op: OP_RMAC,      rd_back: 2'd0, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
      4'd12: u = '{op: OP_RMAC,      rd_back: 2'd0, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
      4'd13: u = '{op: OP_RMAC,      rd_back: 2'd0, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
      4'd14: u = '{op: OP_OUT,       rd_back: 2'd0, weight: 4'd0,     cond: C_OUT_BUSY,
                   target: PC_OUT};
      default: u = '{op: OP_NOP,     rd_back: 2'd0, weight: 4'd0,     cond: C_NEVER,
                   target: PC_IDLE};
    endcase
    return u;
  endfunction

endpackage

// ----- hw/rtl/ese_if.sv -----
// Valid/ready channel interfaces for the speed estimator input and result streams.
interface ese_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] step_count;
  logic        [15:0] elapsed_ms;

  modport source (output valid, step_count, elapsed_ms, input ready);
  modport sink   (input valid, step_count, elapsed_ms, output ready);
endinterface

interface ese_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] avg_speed;

  modport source (output valid, avg_speed, input ready);
  modport sink   (input valid, avg_speed, output ready);
endinterface

// ----- hw/rtl/ese_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional branches.
module ese_seq import ese_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ese_stat_t stat,
  output ese_uop_t  uop
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            taken;

  assign uop = ucode(pc_r);

  always_comb begin
    unique case (uop.cond)
      C_NEVER:    taken = 1'b0;
      C_NO_INPUT: taken = !stat.in_valid;
      C_DIV_MORE: taken = !stat.div_last;
      C_OUT_BUSY: taken = stat.out_busy;
      default:    taken = 1'b0;
    endcase
    if (taken) begin
      pc_nxt = uop.target;
    end else if (pc_r == PC_W'(NSTEPS - 1)) begin
      pc_nxt = PC_IDLE;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- hw/rtl/encoder_speed_estimator.sv -----
// Encoder speed estimator top level: microcoded datapath, speed window and channel registers.
//
// Usage:
//   in_ch  : one transaction per encoder period (step_count, elapsed_ms).
//   out_ch : one transaction per input, the filtered speed in signed Q16.16.
//   cfg_*  : write-only registers, index 0 distance_per_step (Q8.24), index 1
//            encoder_flip. Write only while no item is in flight.
// Timing:
//   An item runs through a 15-step microprogram. The speed divide loop runs at
//   two quotient bits per cycle and dominates; the divide by ten in the filter
//   is a three-step reciprocal multiply. Items do not overlap: the next input
//   is taken only after the result is registered, in the same cycle that
//   out_ch.valid rises, and only while out_ch keeps up. One shared 48x16
//   multiplier does both speed products and the reciprocal multiply.
// Stall: the result sits in an output register; if out_ch is stalled when the
//   next result is ready, the sequencer holds on its last step until the
//   register frees up.
// Reset (rst_n, synchronous): config and control registers zero, window reads as
//   all zeros, sequencer back at its idle step and ready for input.
module encoder_speed_estimator import ese_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ese_in_if.sink                in_ch,
  ese_out_if.source             out_ch
);

  localparam logic signed [31:0] SPD_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SPD_MIN   = 32'sh8000_0000;
  localparam logic        [31:0] Q_LIMIT   = 32'h8000_0000;
  localparam logic        [15:0] MS_PER_S  = 16'd1000;
  // ceil(2^38 / 10): floor(x * RECIP_TEN / 2^38) == x / 10 for x below 2^35
  localparam logic        [47:0] RECIP_TEN = 48'h0006_6666_6667;

  // Config registers
  logic [31:0] dps_r;
  logic        flip_r;

  // Sequencer interface
  ese_uop_t  uop;
  ese_stat_t stat;

  // Item registers
  logic        sneg_r, zero_r;
  logic [15:0] ms_r;

  // Shared multiplier
  logic [47:0] mul_a_r;
  logic [15:0] mul_b_r;
  logic [63:0] prod;
  logic [57:0] acc_r;

  // Serial divider, radix 4
  logic [23:0]          div_r, rem_r;
  logic [31:0]          lo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 ovf_r;
  logic [24:0]          t1, t2;
  logic                 q1, q2;
  logic [23:0]          r1, r2;

  // Speed window
  logic signed [31:0]       win_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]  win_vld_r;
  logic [WIN_AW-1:0]        wp_r;
  logic [WIN_AW-1:0]        rd_idx;
  logic signed [31:0]       rd_r;
  int                       back_s;

  // Filter
  logic signed [35:0] fsum_r;
  logic signed [35:0] wterm;
  logic        [35:0] fmag;
  logic               fneg_r;

  // Speed shaping
  logic        [31:0] q_lim;
  logic signed [31:0] spd_raw, spd;

  // Output register
  logic               out_valid_r;
  logic signed [31:0] out_data_r;
  logic               in_acc;

  ese_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uop   (uop)
  );

  assign in_ch.ready = rst_n && (uop.op == OP_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign stat.in_valid = in_ch.valid;
  assign stat.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.out_busy = out_valid_r && !out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.avg_speed = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dps_r  <= '0;
      flip_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISTANCE_PER_STEP: dps_r  <= cfg_wdata;
        CFG_ENCODER_FLIP:      flip_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign prod = mul_a_r * mul_b_r;

  // Two restoring steps per cycle; remainder stays below the divisor
  always_comb begin
    t1 = {rem_r, lo_r[31]};
    q1 = (t1 >= {1'b0, div_r});
    r1 = q1 ? 24'(t1 - {1'b0, div_r}) : t1[23:0];
    t2 = {r1, lo_r[30]};
    q2 = (t2 >= {1'b0, div_r});
    r2 = q2 ? 24'(t2 - {1'b0, div_r}) : t2[23:0];
  end

  // Quotient to signed speed: clamp, sign, flip
  always_comb begin
    q_lim = (ovf_r || lo_r > Q_LIMIT) ? Q_LIMIT : lo_r;
    if (zero_r) begin
      spd_raw = '0;
    end else if (sneg_r) begin
      spd_raw = 32'sd0 - signed'(q_lim);
    end else if (q_lim == Q_LIMIT) begin
      spd_raw = SPD_MAX;
    end else begin
      spd_raw = signed'(q_lim);
    end
    if (!flip_r) begin
      spd = spd_raw;
    end else if (spd_raw == SPD_MIN) begin
      spd = SPD_MAX;
    end else begin
      spd = 32'sd0 - spd_raw;
    end
  end

  // Window slot behind the write pointer, wrapped
  always_comb begin
    back_s = int'(wp_r) - int'(uop.rd_back);
    for (int i = 0; i < 3; i++) begin
      if (back_s < 0) back_s = back_s + WINDOW_DEPTH;
    end
    rd_idx = WIN_AW'(back_s);
  end

  assign wterm = 36'(rd_r) * 36'(signed'({1'b0, uop.weight}));
  assign fmag  = fsum_r[35] ? 36'(-fsum_r) : 36'(fsum_r);

  // Datapath
  always_ff @(posedge clk) begin
    case (uop.op)
      OP_LOAD: begin
        if (in_acc) begin
          sneg_r  <= in_ch.step_count[15];
          zero_r  <= (in_ch.elapsed_ms == '0) || (in_ch.step_count == '0);
          ms_r    <= in_ch.elapsed_ms;
          mul_a_r <= {16'h0, dps_r};
          mul_b_r <= in_ch.step_count[15] ? 16'(-in_ch.step_count) : 16'(in_ch.step_count);
        end
      end
      OP_MUL: begin
        acc_r   <= prod[57:0];
        mul_a_r <= prod[47:0];
        mul_b_r <= MS_PER_S;
      end
      OP_SPD_INIT: begin
        div_r <= {ms_r, 8'h00};
        ovf_r <= (acc_r >= {2'b00, ms_r, 8'h00, 32'h0});
        rem_r <= acc_r[55:32];
        lo_r  <= acc_r[31:0];
        cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= r2;
        lo_r  <= {lo_r[29:0], q1, q2};
        cnt_r <= cnt_r + 1'b1;
      end
      OP_FCLR: begin
        fsum_r <= '0;
      end
      OP_FACC: begin
        fsum_r <= fsum_r + wterm;
      end
      // magnitude times the reciprocal, 16 bits of it per step; lo_r holds the rest
      OP_FLT_INIT: begin
        fneg_r  <= fsum_r[35];
        mul_a_r <= 48'(fmag);
        mul_b_r <= RECIP_TEN[15:0];
        lo_r    <= RECIP_TEN[47:16];
        acc_r   <= '0;
      end
      OP_RMAC: begin
        acc_r   <= (acc_r >> 16) + prod[57:0];
        mul_b_r <= lo_r[15:0];
        lo_r    <= lo_r >> 16;
      end
      // after three steps acc_r holds the product over 2^32; quotient is acc_r >> 6
      OP_OUT: begin
        if (!stat.out_busy) begin
          out_data_r <= fneg_r ? 32'sd0 - signed'(acc_r[37:6]) : signed'(acc_r[37:6]);
        end
      end
      default: ;
    endcase
  end

  // Window storage and registered read
  always_ff @(posedge clk) begin
    if (uop.op == OP_SPD_STORE) begin
      win_mem[wp_r] <= spd;
    end
    rd_r <= win_vld_r[rd_idx] ? win_mem[rd_idx] : '0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      win_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (uop.op == OP_SPD_STORE) begin
        win_vld_r[wp_r] <= 1'b1;
        wp_r <= (wp_r == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (uop.op == OP_OUT && !stat.out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Checks
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(wp_r) < WINDOW_DEPTH)
    else $error("window write pointer out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (uop.op == OP_MUL))
    else $error("accepted transaction did not start the multiply step");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(uop.op == OP_OUT))
    else $error("result raised outside the output step");

endmodule
